[hw/rtl/lcdt_pkg.sv]
// ----------------------------------------------------------------------------
// lcdt_pkg
// Shared types and constants for the LCD mode and scan-line timer.
// ----------------------------------------------------------------------------
package lcdt_pkg;

  // Display mode codes
  localparam logic [1:0] MODE_OAM    = 2'd0;
  localparam logic [1:0] MODE_VRAM   = 2'd1;
  localparam logic [1:0] MODE_HBLANK = 2'd2;

  // Line timer thresholds for the end of OAM scan and VRAM scan
  localparam int OAM_END  = 80;
  localparam int VRAM_END = 252;

  // Configuration register indexes
  localparam int          CFG_IDX_W       = 3;
  localparam logic [2:0]  CFG_COMPARE     = 3'd0;
  localparam logic [2:0]  CFG_HBLANK_EN   = 3'd1;
  localparam logic [2:0]  CFG_VBLANK_EN   = 3'd2;
  localparam logic [2:0]  CFG_OAM_EN      = 3'd3;
  localparam logic [2:0]  CFG_MATCH_EN    = 3'd4;

  // Configuration registers
  typedef struct packed {
    logic [7:0] compare_line;
    logic       hblank_irq_enable;
    logic       vblank_irq_enable;
    logic       oam_irq_enable;
    logic       match_irq_enable;
  } lcdt_cfg_t;

  // Timer state carried from one word to the next (line timer kept apart)
  typedef struct packed {
    logic [1:0]  mode;
    logic [7:0]  line;
    logic        match;
    logic        last_status;
    logic [15:0] frames;
  } lcdt_state_t;

  // One result word
  typedef struct packed {
    logic [1:0]  mode;
    logic [7:0]  line;
    logic        line_match;
    logic        status_level;
    logic        lcd_irq;
    logic        vblank_irq;
    logic        render_line;
    logic [7:0]  rendered_line;
    logic [15:0] frame_count;
  } lcdt_res_t;

endpackage

[hw/rtl/lcdt_step.sv]
// ----------------------------------------------------------------------------
// lcdt_step
// Next-state logic of the timer: adds the elapsed cycles, runs the mode
// cascade, wraps the line and forms the status and interrupt flags.
// ----------------------------------------------------------------------------
module lcdt_step
  import lcdt_pkg::*;
#(
  parameter int LINE_CYCLES   = 456,
  parameter int VISIBLE_LINES = 144,
  parameter int LAST_LINE     = 153,
  localparam int TIMER_W      = $clog2(LINE_CYCLES)
) (
  input  lcdt_cfg_t            cfg_i,
  input  logic [8:0]           delta_i,
  input  logic [TIMER_W-1:0]   timer_i,
  input  lcdt_state_t          state_i,
  output logic [TIMER_W-1:0]   timer_o,
  output lcdt_state_t          state_o,
  output lcdt_res_t            res_o
);

  // One extra bit holds timer plus delta
  localparam int              SUM_W    = TIMER_W + 1;
  localparam logic [SUM_W-1:0] LC_S    = SUM_W'(LINE_CYCLES);
  localparam logic [SUM_W-1:0] MAXD_S  = SUM_W'(LINE_CYCLES - 1);
  localparam logic [SUM_W-1:0] OAM_S   = SUM_W'(OAM_END);
  localparam logic [SUM_W-1:0] VRAM_S  = SUM_W'(VRAM_END);
  localparam logic [7:0]       VIS_L   = 8'(VISIBLE_LINES);
  localparam logic [7:0]       LAST_L  = 8'(LAST_LINE);

  logic [SUM_W-1:0] delta_c;
  logic [SUM_W-1:0] t;
  logic [1:0]       mode;
  logic [7:0]       line;
  logic             match;
  logic [15:0]      frames;
  logic             status;
  logic             vblank;
  logic             render;
  logic [7:0]       rline;
  logic             wrapped;

  // Clamp so at most one line completes per word
  assign delta_c = (SUM_W'(delta_i) > MAXD_S) ? MAXD_S : SUM_W'(delta_i);

  always_comb begin
    t       = SUM_W'(timer_i) + delta_c;
    mode    = state_i.mode;
    line    = state_i.line;
    match   = state_i.match;
    frames  = state_i.frames;
    status  = 1'b0;
    vblank  = 1'b0;
    render  = 1'b0;
    rline   = 8'd0;
    wrapped = 1'b0;

    // First pass of the mode cascade
    case (state_i.mode)
      MODE_OAM: begin
        if (t < OAM_S) begin
          mode = MODE_OAM;
        end else if (t < VRAM_S) begin
          mode = MODE_VRAM;
        end else begin
          status = cfg_i.hblank_irq_enable;
          if (t < LC_S) mode = MODE_HBLANK;
          else          wrapped = 1'b1;
        end
      end
      MODE_VRAM: begin
        if (t < VRAM_S) begin
          mode = MODE_VRAM;
        end else begin
          status = cfg_i.hblank_irq_enable;
          if (t < LC_S) mode = MODE_HBLANK;
          else          wrapped = 1'b1;
        end
      end
      MODE_HBLANK: begin
        if (t < LC_S) mode = MODE_HBLANK;
        else          wrapped = 1'b1;
      end
      default: begin
        mode = MODE_OAM;
      end
    endcase

    // Line complete: advance the line, then rerun the cascade on the rest
    if (wrapped) begin
      t = t - LC_S;
      if (line < VIS_L) begin
        render = 1'b1;
        rline  = line;
        line   = line + 8'd1;
      end else if (line == VIS_L) begin
        if (cfg_i.vblank_irq_enable) status = 1'b1;
        frames = frames + 16'd1;
        vblank = 1'b1;
        line   = line + 8'd1;
      end else if (line == LAST_L) begin
        line = 8'd0;
      end else begin
        line = line + 8'd1;
      end
      match = (line == cfg_i.compare_line);
      if (match && cfg_i.match_irq_enable) status = 1'b1;
      if (cfg_i.oam_irq_enable) status = 1'b1;

      if (t < OAM_S) begin
        mode = MODE_OAM;
      end else if (t < VRAM_S) begin
        mode = MODE_VRAM;
      end else begin
        mode = MODE_HBLANK;
        if (cfg_i.hblank_irq_enable) status = 1'b1;
      end
    end
  end

  // Outputs
  assign timer_o             = t[TIMER_W-1:0];
  assign state_o.mode        = mode;
  assign state_o.line        = line;
  assign state_o.match       = match;
  assign state_o.last_status = status;
  assign state_o.frames      = frames;

  assign res_o.mode          = mode;
  assign res_o.line          = line;
  assign res_o.line_match    = match;
  assign res_o.status_level  = status;
  assign res_o.lcd_irq       = status & ~state_i.last_status;
  assign res_o.vblank_irq    = vblank;
  assign res_o.render_line   = render;
  assign res_o.rendered_line = rline;
  assign res_o.frame_count   = frames;

endmodule

[hw/rtl/lcd_mode_scanline_timer_top.sv]
// ----------------------------------------------------------------------------
// lcd_mode_scanline_timer_top
// LCD mode and scan-line timer: input register, combinational step logic and
// a result register with its own valid.
// ----------------------------------------------------------------------------
// 2 register stages: input register, then result register. One word per cycle
// while the result is not stalled; the step logic forms all next state combinationally.
// A stalled result still leaves the input register free to take one word.
// Reset clears timer, mode, line, flags, frame count and config registers.
module lcd_mode_scanline_timer_top
  import lcdt_pkg::*;
#(
  parameter int LINE_CYCLES   = 456,
  parameter int VISIBLE_LINES = 144,
  parameter int LAST_LINE     = 153
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // configuration write channel
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [7:0]            cfg_data_i,
  // input channel
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [8:0]            cycles_elapsed_i,
  // output channel
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [1:0]            mode_o,
  output logic [7:0]            line_o,
  output logic                  line_match_o,
  output logic                  status_level_o,
  output logic                  lcd_irq_o,
  output logic                  vblank_irq_o,
  output logic                  render_line_o,
  output logic [7:0]            rendered_line_o,
  output logic [15:0]           frame_count_o
);

  localparam int TIMER_W = $clog2(LINE_CYCLES);

  lcdt_cfg_t            cfg_q;
  logic                 in_valid_q;
  logic [8:0]           delta_q;
  logic [TIMER_W-1:0]   timer_q, timer_d;
  lcdt_state_t          state_q, state_d;
  lcdt_res_t            res_q, res_d;
  logic                 out_valid_q;
  logic                 advance;

  // Configuration writes, always ready
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_COMPARE:   cfg_q.compare_line      <= cfg_data_i;
        CFG_HBLANK_EN: cfg_q.hblank_irq_enable <= cfg_data_i[0];
        CFG_VBLANK_EN: cfg_q.vblank_irq_enable <= cfg_data_i[0];
        CFG_OAM_EN:    cfg_q.oam_irq_enable    <= cfg_data_i[0];
        CFG_MATCH_EN:  cfg_q.match_irq_enable  <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Handshake: the input word moves on when the result register is free
  assign advance    = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && out_valid_q && out_stall_i;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      delta_q <= cycles_elapsed_i;
    end
  end

  // Step logic
  lcdt_step #(
    .LINE_CYCLES   (LINE_CYCLES),
    .VISIBLE_LINES (VISIBLE_LINES),
    .LAST_LINE     (LAST_LINE)
  ) u_step (
    .cfg_i   (cfg_q),
    .delta_i (delta_q),
    .timer_i (timer_q),
    .state_i (state_q),
    .timer_o (timer_d),
    .state_o (state_d),
    .res_o   (res_d)
  );

  // Timer state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timer_q            <= '0;
      state_q.mode       <= MODE_OAM;
      state_q.line       <= 8'd0;
      state_q.match      <= 1'b0;
      state_q.last_status <= 1'b0;
      state_q.frames     <= 16'd0;
    end else if (advance) begin
      timer_q <= timer_d;
      state_q <= state_d;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign mode_o          = res_q.mode;
  assign line_o          = res_q.line;
  assign line_match_o    = res_q.line_match;
  assign status_level_o  = res_q.status_level;
  assign lcd_irq_o       = res_q.lcd_irq;
  assign vblank_irq_o    = res_q.vblank_irq;
  assign render_line_o   = res_q.render_line;
  assign rendered_line_o = res_q.rendered_line;
  assign frame_count_o   = res_q.frame_count;

  // Assertions
  a_timer_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    {1'b0, timer_q} < (TIMER_W + 1)'(LINE_CYCLES))
    else $error("line timer out of range");

  a_mode_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.mode != 2'd3)
    else $error("illegal mode state");

  a_vblank_line: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && res_q.vblank_irq |-> res_q.line == 8'(VISIBLE_LINES + 1))
    else $error("vblank pulse on wrong line");

  a_render_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !res_q.render_line |-> res_q.rendered_line == 8'd0)
    else $error("rendered line set without render flag");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_q && out_stall_i && in_valid_q)
    else $error("input stalled while result register free");

endmodule

[tb/lcd_mode_scanline_timer_top_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcd_mode_scanline_timer_top_test
// Self-checking bench for the LCD mode and scan-line timer. Cycle-count words
// go in through a bursty sender while the result side stalls on its own
// pattern. A scoreboard keeps a cycle-exact copy of the timer, predicts every
// result word and compares it field by field. Register settings change
// between phases, only while the block is drained.
// ----------------------------------------------------------------------------
module lcd_mode_scanline_timer_top_test;
  import lcdt_pkg::*;

  localparam int LINE_CYCLES    = 456;
  localparam int VISIBLE_LINES  = 144;
  localparam int LAST_LINE      = 153;
  localparam int MAX_DELTA      = LINE_CYCLES - 1;
  localparam int NUM_PHASES     = 8;
  localparam int WORDS_PER_PH   = 210;
  localparam int SETTLE_CYCLES  = 8;
  localparam int WATCHDOG_LIMIT = 2000;

  // Scoreboard: timer model plus queue of predicted result words
  class scanline_scoreboard;
    logic [7:0]  compare_line = '0;
    logic        hblank_en    = 1'b0;
    logic        vblank_en    = 1'b0;
    logic        oam_en       = 1'b0;
    logic        match_en     = 1'b0;

    int unsigned tmr_acc      = 0;
    logic [1:0]  mode_q       = MODE_OAM;
    logic [7:0]  cur_line     = '0;
    logic        match_q      = 1'b0;
    logic        last_status  = 1'b0;
    logic [15:0] frames       = '0;

    lcdt_res_t   pending_q[$];
    int          mismatches   = 0;
    int          results      = 0;
    int          frame_ends   = 0;
    int          lcd_irqs     = 0;
    int          renders      = 0;

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [7:0] data);
      case (idx)
        CFG_COMPARE:   compare_line = data;
        CFG_HBLANK_EN: hblank_en    = data[0];
        CFG_VBLANK_EN: vblank_en    = data[0];
        CFG_OAM_EN:    oam_en       = data[0];
        CFG_MATCH_EN:  match_en     = data[0];
        default: ;
      endcase
    endfunction

    // Advance the timer by one word and queue the result it must produce
    function void note_word(logic [8:0] cyc);
      lcdt_res_t   r;
      int unsigned delta;
      logic        status;
      logic        vblank;
      logic        render;
      logic [7:0]  rline;
      int          pass_n;
      status = 1'b0;
      vblank = 1'b0;
      render = 1'b0;
      rline  = '0;
      delta  = (cyc > MAX_DELTA) ? MAX_DELTA : cyc;
      tmr_acc += delta;
      // at most one line ends per word, so the cascade runs twice at most
      for (pass_n = 0; pass_n < 2; pass_n++) begin
        if (mode_q == MODE_OAM) begin
          if (tmr_acc < OAM_END) break;
          mode_q = MODE_VRAM;
        end
        if (mode_q == MODE_VRAM) begin
          if (tmr_acc < VRAM_END) break;
          mode_q = MODE_HBLANK;
          if (hblank_en) status = 1'b1;
        end
        if (mode_q == MODE_HBLANK) begin
          if (tmr_acc < LINE_CYCLES) break;
          tmr_acc -= LINE_CYCLES;
          // visible check comes first, then the frame wrap
          if (cur_line < VISIBLE_LINES) begin
            render   = 1'b1;
            rline    = cur_line;
            cur_line = cur_line + 8'd1;
          end else if (cur_line == VISIBLE_LINES) begin
            if (vblank_en) status = 1'b1;
            frames   = frames + 16'd1;
            vblank   = 1'b1;
            cur_line = cur_line + 8'd1;
          end else if (cur_line == LAST_LINE) begin
            cur_line = '0;
          end else begin
            cur_line = cur_line + 8'd1;
          end
          match_q = (cur_line == compare_line);
          if (match_q && match_en) status = 1'b1;
          if (oam_en) status = 1'b1;
          mode_q = MODE_OAM;
        end else begin
          // unreachable mode code falls back to OAM scan
          mode_q = MODE_OAM;
          break;
        end
      end
      r.mode          = mode_q;
      r.line          = cur_line;
      r.line_match    = match_q;
      r.status_level  = status;
      r.lcd_irq       = status & ~last_status;
      r.vblank_irq    = vblank;
      r.render_line   = render;
      r.rendered_line = rline;
      r.frame_count   = frames;
      last_status     = status;
      frame_ends     += vblank;
      lcd_irqs       += r.lcd_irq;
      renders        += render;
      pending_q.push_back(r);
    endfunction

    function string show(lcdt_res_t r);
      return $sformatf({"mode=%0d line=%0d match=%0b stat=%0b irq=%0b ",
                        "vbl=%0b rend=%0b rl=%0d fc=%0d"},
                       r.mode, r.line, r.line_match, r.status_level, r.lcd_irq,
                       r.vblank_irq, r.render_line, r.rendered_line, r.frame_count);
    endfunction

    function void check_word(lcdt_res_t got);
      lcdt_res_t want;
      results++;
      if (pending_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("[%0t] result word with none pending: %s", $realtime,
                                       show(got));
        return;
      end
      want = pending_q.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("[%0t] result %0d differs", $realtime, results);
          $display("  expected %s", show(want));
          $display("  actual   %s", show(got));
        end
      end
    endfunction

    function int pending();
      return pending_q.size();
    endfunction
  endclass

  // DUT ports, all driven from time zero
  logic                 clk_i            = 1'b0;
  logic                 rst_ni           = 1'b0;
  logic                 cfg_valid_i      = 1'b0;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i      = CFG_COMPARE;
  logic [7:0]           cfg_data_i       = '0;
  logic                 in_valid_i       = 1'b0;
  logic                 in_stall_o;
  logic [8:0]           cycles_elapsed_i = '0;
  logic                 out_valid_o;
  logic                 out_stall_i      = 1'b0;
  logic [1:0]           mode_o;
  logic [7:0]           line_o;
  logic                 line_match_o;
  logic                 status_level_o;
  logic                 lcd_irq_o;
  logic                 vblank_irq_o;
  logic                 render_line_o;
  logic [7:0]           rendered_line_o;
  logic [15:0]          frame_count_o;

  scanline_scoreboard sb = new();
  int words_in    = 0;
  int settings    = 0;
  int burst_left  = 0;
  int idle_cycles = 0;
  int seg_left    = 0;
  int stall_kind  = 0;
  int stall_tick  = 0;

  lcd_mode_scanline_timer_top #(
    .LINE_CYCLES  (LINE_CYCLES),
    .VISIBLE_LINES(VISIBLE_LINES),
    .LAST_LINE    (LAST_LINE)
  ) u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .cycles_elapsed_i(cycles_elapsed_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .mode_o          (mode_o),
    .line_o          (line_o),
    .line_match_o    (line_match_o),
    .status_level_o  (status_level_o),
    .lcd_irq_o       (lcd_irq_o),
    .vblank_irq_o    (vblank_irq_o),
    .render_line_o   (render_line_o),
    .rendered_line_o (rendered_line_o),
    .frame_count_o   (frame_count_o)
  );

  // 4 ns clock
  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // Handshake monitor: register writes, accepted words, result words
  always @(posedge clk_i) begin
    lcdt_res_t got;
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) sb.write_reg(cfg_index_i, cfg_data_i);
      if (in_valid_i && !in_stall_o) begin
        sb.note_word(cycles_elapsed_i);
        words_in++;
      end
      if (out_valid_o && !out_stall_i) begin
        got = {mode_o, line_o, line_match_o, status_level_o, lcd_irq_o, vblank_irq_o,
               render_line_o, rendered_line_o, frame_count_o};
        sb.check_word(got);
      end
    end
  end

  // Watchdog on cycles without any handshake
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("[%0t] watchdog: no handshake for %0d cycles", $realtime, idle_cycles);
      $display("Mismatches found");
      $finish;
    end
  end

  // Result-side stall: segments of no stall, light, heavy and periodic stall
  always @(negedge clk_i) begin
    if (seg_left == 0) begin
      stall_kind = $urandom_range(0, 3);
      seg_left   = $urandom_range(40, 300);
    end
    seg_left--;
    stall_tick++;
    case (stall_kind)
      0: out_stall_i <= 1'b0;
      1: out_stall_i <= ($urandom_range(0, 3) == 0);
      2: out_stall_i <= ($urandom_range(0, 9) < 6);
      default: out_stall_i <= ((stall_tick % 7) < 3);
    endcase
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Enable bits ride in bit 0; upper bits are noise the block must drop
  task automatic apply_setting(input logic [7:0] cmp, input logic h, input logic v,
                               input logic o, input logic m);
    write_reg(CFG_COMPARE, cmp);
    write_reg(CFG_HBLANK_EN, (8'($urandom) & 8'hFE) | 8'(h));
    write_reg(CFG_VBLANK_EN, (8'($urandom) & 8'hFE) | 8'(v));
    write_reg(CFG_OAM_EN, (8'($urandom) & 8'hFE) | 8'(o));
    write_reg(CFG_MATCH_EN, (8'($urandom) & 8'hFE) | 8'(m));
    settings++;
  endtask

  task automatic send_word(input logic [8:0] cyc);
    @(negedge clk_i);
    in_valid_i       <= 1'b1;
    cycles_elapsed_i <= cyc;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // Sender bursts: random length, random gap (often none) between them
  task automatic paced_word(input logic [8:0] cyc);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 10);
      if (gap > 0) begin
        @(negedge clk_i);
        in_valid_i <= 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    send_word(cyc);
  endtask

  // Let every predicted word come back, then let the block settle
  task automatic drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Mostly short deltas so lines build up; some long and clamped ones
  function automatic logic [8:0] random_delta();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 55) return 9'($urandom_range(0, 100));
    if (pick < 80) return 9'($urandom_range(101, MAX_DELTA));
    if (pick < 92) return 9'($urandom_range(LINE_CYCLES, 511));
    return ($urandom_range(0, 1) != 0) ? 9'(MAX_DELTA) : 9'd0;
  endfunction

  // Main sequence
  initial begin
    logic [8:0] directed[$];
    int         ph;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: mode edges, exact line end, large delta with re-entry, single bits
    apply_setting(8'd1, 1'b1, 1'b1, 1'b1, 1'b1);
    directed = '{9'd0, 9'd79, 9'd1, 9'd171, 9'd1, 9'd203, 9'd1, 9'd455, 9'd511,
                 9'd456, 9'd256, 9'd128, 9'd64, 9'd32, 9'd16, 9'd8, 9'd4, 9'd2, 9'd0};
    foreach (directed[i]) paced_word(directed[i]);
    drain();

    // Random phases, each under its own register setting
    for (ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        0: apply_setting(8'd0, 1'b1, 1'b1, 1'b1, 1'b1);
        1: apply_setting(8'd255, 1'b0, 1'b0, 1'b0, 1'b0);
        2: apply_setting(8'(LAST_LINE), 1'b1, 1'b0, 1'b0, 1'b1);
        3: apply_setting(8'(VISIBLE_LINES), 1'b0, 1'b1, 1'b0, 1'b1);
        4: apply_setting(8'($urandom_range(0, LAST_LINE)), 1'($urandom), 1'($urandom),
                         1'($urandom), 1'($urandom));
        5: apply_setting(8'($urandom_range(0, 255)), 1'($urandom), 1'($urandom),
                         1'($urandom), 1'($urandom));
        6: apply_setting(8'($urandom_range(0, LAST_LINE)), 1'b0, 1'b0, 1'b1, 1'b0);
        default: apply_setting(8'($urandom_range(0, LAST_LINE)), 1'($urandom),
                               1'($urandom), 1'($urandom), 1'($urandom));
      endcase
      repeat (WORDS_PER_PH) paced_word(random_delta());
      drain();
    end

    $display("Run covered %0d words and %0d result words over %0d register settings.",
             words_in, sb.results, settings);
    $display("Seen %0d frame ends, %0d rendered lines and %0d LCD interrupts.",
             sb.frame_ends, sb.renders, sb.lcd_irqs);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
